// ===== design/rgbe_pkg.sv =====
// Package: payload types and constants for the RGBE shared-exponent codec.
`default_nettype none
package rgbe_pkg;

  typedef struct packed {
    logic        cmd;
    logic [31:0] red_in;
    logic [31:0] green_in;
    logic [31:0] blue_in;
    logic [31:0] packed_in;
  } in_t;

  typedef struct packed {
    logic [31:0] packed_out;
    logic [31:0] red_out;
    logic [31:0] green_out;
    logic [31:0] blue_out;
    logic        overflow;
  } out_t;

  localparam logic        CMD_PACK   = 1'b0;
  localparam logic        CMD_UNPACK = 1'b1;
  // 1e-32f as an IEEE single bit pattern
  localparam logic [31:0] PACK_FLOOR = 32'h0A4FB11F;
  localparam logic [31:0] INF_BITS   = 32'h7F800000;
  localparam logic [7:0]  EXP_LIMIT  = 8'd254;
  localparam logic [8:0]  UNPACK_OFS = 9'd9;  // 136 - 127

endpackage
`default_nettype wire

// ===== design/rgbe_shared_exponent_codec.sv =====
// Top level: pipelined RGBE pack/unpack codec, one transfer per cycle unless the output stalls.
// out_valid_o comes from the last of three register stages.
// Throughput: one item per clock unless stalled; stage one clamps and finds the largest channel,
// stage two shifts mantissas into bytes or normalizes unpacked bytes, stage three holds results.
// Reset: rst_ni asynchronous, active low, clears the stage valid bits only.
// A stage advances whenever it is empty or the stage after it advances.
`default_nettype none
module rgbe_shared_exponent_codec (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire rgbe_pkg::in_t  in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output rgbe_pkg::out_t      out_data_o
);

  // clamp a channel: negatives and minus infinity to zero, flag NaN or plus infinity
  function automatic logic [31:0] clamp_f(input logic [31:0] x);
    if (x[30:0] >= rgbe_pkg::INF_BITS[30:0] || x[31]) clamp_f = '0;
    else clamp_f = x;
  endfunction

  function automatic logic bad_f(input logic [31:0] x);
    bad_f = (x[30:0] > rgbe_pkg::INF_BITS[30:0]) ||
            (x[30:0] == rgbe_pkg::INF_BITS[30:0] && !x[31]);
  endfunction

  function automatic logic [7:0] chan_byte_f(input logic [31:0] c, input logic [7:0] ev);
    logic [7:0]  ec;
    logic [23:0] m;
    logic [9:0]  s;
    ec = c[30:23];
    m  = {1'b0, c[22:0]};
    if (ec == 8'd0) ec = 8'd1;
    else m[23] = 1'b1;
    s = 10'd16 + {2'b0, ev} - {2'b0, ec};
    if (s >= 10'd32) chan_byte_f = '0;
    else chan_byte_f = 8'(m >> s[4:0]);
  endfunction

  function automatic logic [31:0] unpack_f(input logic [7:0] b, input logic [7:0] ex);
    logic [2:0] p;
    logic [9:0] biased;
    logic [7:0] mb;
    p = '0;
    for (int i = 1; i < 8; i++) if (b[i]) p = 3'(i);
    biased = {7'b0, p} + {2'b0, ex} - {1'b0, rgbe_pkg::UNPACK_OFS};
    mb = b << (3'd7 - p);
    if (b == 8'd0) unpack_f = '0;
    else if (!biased[9] && biased != 10'd0)
      unpack_f = {1'b0, biased[7:0], mb[6:0], 16'b0};
    else unpack_f = 32'({24'b0, b} << (ex + 8'd13));
  endfunction

  logic [2:0] vld_q;
  logic [2:0] adv;
  assign adv[2] = !vld_q[2] || out_ready_i;
  assign adv[1] = !vld_q[1] || adv[2];
  assign adv[0] = !vld_q[0] || adv[1];
  assign in_ready_o = adv[0];

  // stage one: clamp, max, classify
  logic        s1_cmd_q, s1_bad_q, s1_zero_q, s1_ovf_q;
  logic [31:0] s1_r_q, s1_g_q, s1_b_q, s1_w_q;
  logic [7:0]  s1_ev_q;
  logic [31:0] r_c, g_c, b_c, v_c;
  logic        bad_c;
  always_comb begin
    r_c = clamp_f(in_data_i.red_in);
    g_c = clamp_f(in_data_i.green_in);
    b_c = clamp_f(in_data_i.blue_in);
    bad_c = bad_f(in_data_i.red_in) | bad_f(in_data_i.green_in) | bad_f(in_data_i.blue_in);
    v_c = r_c;
    if (g_c > v_c) v_c = g_c;
    if (b_c > v_c) v_c = b_c;
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      s1_cmd_q  <= in_data_i.cmd;
      s1_r_q    <= r_c;
      s1_g_q    <= g_c;
      s1_b_q    <= b_c;
      s1_w_q    <= in_data_i.packed_in;
      s1_bad_q  <= bad_c;
      s1_zero_q <= v_c < rgbe_pkg::PACK_FLOOR;
      s1_ovf_q  <= v_c[30:23] >= rgbe_pkg::EXP_LIMIT;
      s1_ev_q   <= v_c[30:23];
    end
  end

  // stage two: byte extraction or unpack normalization
  rgbe_pkg::out_t s2_d, s2_q, s3_q;
  always_comb begin
    s2_d = '0;
    if (s1_cmd_q == rgbe_pkg::CMD_PACK) begin
      if (s1_bad_q || (!s1_zero_q && s1_ovf_q)) begin
        s2_d.packed_out = '1;
        s2_d.overflow   = 1'b1;
      end else if (!s1_zero_q) begin
        s2_d.packed_out = {s1_ev_q + 8'd2, chan_byte_f(s1_b_q, s1_ev_q),
                           chan_byte_f(s1_g_q, s1_ev_q), chan_byte_f(s1_r_q, s1_ev_q)};
      end
    end else if (s1_w_q[31:24] != 8'd0) begin
      s2_d.red_out   = unpack_f(s1_w_q[7:0],   s1_w_q[31:24]);
      s2_d.green_out = unpack_f(s1_w_q[15:8],  s1_w_q[31:24]);
      s2_d.blue_out  = unpack_f(s1_w_q[23:16], s1_w_q[31:24]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[1]) s2_q <= s2_d;
    if (adv[2]) s3_q <= s2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) vld_q[0] <= in_valid_i;
      if (adv[1]) vld_q[1] <= vld_q[0];
      if (adv[2]) vld_q[2] <= vld_q[1];
    end
  end

  assign out_valid_o = vld_q[2];
  assign out_data_o  = s3_q;

  // hold the output stage while stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output changed under stall");
  // overflow only comes with an all-ones word
  a_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.overflow |-> out_data_o.packed_out == '1)
    else $error("overflow without saturated word");
  // a full pipe with a stalled sink takes no input
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q == 3'b111 && !out_ready_i |-> !in_ready_o)
    else $error("input taken into full pipe");

endmodule
`default_nettype wire

// ===== sim/rgbe_shared_exponent_codec_test.sv =====
// Testbench for the RGBE shared-exponent codec: directed and random pack/unpack traffic.
`timescale 1ns / 100ps
module rgbe_shared_exponent_codec_test;

  localparam int NUM_RANDOM   = 1950;
  localparam int STALL_LIMIT  = 2000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  rgbe_pkg::in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  rgbe_pkg::out_t out_data_o;

  int error_count = 0;
  int n_pack = 0;
  int n_unpack = 0;
  int n_ovf = 0;
  bit stim_done = 1'b0;

  always #10 clk_i = ~clk_i;

  rgbe_shared_exponent_codec uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o)
  );

  // Print one mismatch line and count it.
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %08h want %08h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Clamp one channel: negatives and minus infinity become zero, NaN and
  // plus infinity flag the whole pixel as bad.
  function automatic logic [31:0] clamp_channel(input logic [31:0] x, inout bit bad);
    if (x[30:0] >= 31'h7F800000) begin
      if (x[30:0] > 31'h7F800000 || !x[31]) bad = 1'b1;
      return '0;
    end
    if (x[31]) return '0;
    return x;
  endfunction

  // Shift a channel mantissa so that the largest channel lands in [128,255].
  function automatic logic [7:0] channel_byte(input logic [31:0] c, input logic [7:0] ev);
    logic [7:0] ec;
    logic [23:0] m;
    int s;
    ec = c[30:23];
    m = {1'b0, c[22:0]};
    if (ec == 0) ec = 8'd1;
    else m[23] = 1'b1;
    s = 16 + int'(ev) - int'(ec);
    if (s >= 32) return '0;
    return 8'((m >> s));
  endfunction

  // Byte times 2^(ex-136) as IEEE single bits; small ones become subnormal.
  function automatic logic [31:0] byte_as_float(input logic [7:0] b, input logic [7:0] ex);
    int p;
    int biased;
    logic [31:0] wide;
    if (b == 0) return '0;
    p = 0;
    while (p < 7 && (b >> (p + 1)) != 0) p++;
    biased = p + int'(ex) - 9;
    wide = {24'd0, b};
    if (biased >= 1) return {1'b0, 8'(biased), 23'((wide << (23 - p)))};
    return wide << (int'(ex) + 13);
  endfunction

  function automatic rgbe_pkg::out_t predict_pixel(input rgbe_pkg::in_t x);
    rgbe_pkg::out_t o;
    bit bad;
    logic [31:0] r, g, b, v;
    logic [7:0] ev;
    o = '0;
    bad = 1'b0;
    if (x.cmd == rgbe_pkg::CMD_PACK) begin
      r = clamp_channel(x.red_in, bad);
      g = clamp_channel(x.green_in, bad);
      b = clamp_channel(x.blue_in, bad);
      if (bad) begin
        o.packed_out = '1;
        o.overflow = 1'b1;
        return o;
      end
      v = r;
      if (g > v) v = g;
      if (b > v) v = b;
      // Positive floats order like their bit patterns.
      if (v < rgbe_pkg::PACK_FLOOR) return o;
      ev = v[30:23];
      if (ev >= rgbe_pkg::EXP_LIMIT) begin
        o.packed_out = '1;
        o.overflow = 1'b1;
        return o;
      end
      o.packed_out = {8'(ev + 8'd2), channel_byte(b, ev), channel_byte(g, ev),
                      channel_byte(r, ev)};
    end else if (x.packed_in[31:24] != 0) begin
      o.red_out   = byte_as_float(x.packed_in[7:0], x.packed_in[31:24]);
      o.green_out = byte_as_float(x.packed_in[15:8], x.packed_in[31:24]);
      o.blue_out  = byte_as_float(x.packed_in[23:16], x.packed_in[31:24]);
    end
    return o;
  endfunction

  class pixel_scoreboard;
    rgbe_pkg::out_t pending[$];

    function void note_input(rgbe_pkg::in_t x);
      pending.insert(pending.size(), predict_pixel(x));
    endfunction

    task check_result(rgbe_pkg::out_t got);
      rgbe_pkg::out_t want;
      if (pending.size() == 0) begin
        report_mismatch("unexpected result", got.packed_out, '0);
        return;
      end
      want = pending.pop_front();
      if (want.overflow) n_ovf++;
      if (got.packed_out !== want.packed_out)
        report_mismatch("packed_out", got.packed_out, want.packed_out);
      if (got.red_out !== want.red_out) report_mismatch("red_out", got.red_out, want.red_out);
      if (got.green_out !== want.green_out)
        report_mismatch("green_out", got.green_out, want.green_out);
      if (got.blue_out !== want.blue_out)
        report_mismatch("blue_out", got.blue_out, want.blue_out);
      if (got.overflow !== want.overflow)
        report_mismatch("overflow", 32'(got.overflow), 32'(want.overflow));
    endtask
  endclass

  pixel_scoreboard sb = new();

  // Sample both channels at the rising edge; note inputs, check outputs.
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_input(in_data_i);
      if (out_valid_o && out_ready_i) sb.check_result(out_data_o);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (!in_valid_i && sb.pending.size() == 0 && !stim_done)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
        $display("[rgbe_shared_exponent_codec] ERROR");
        $finish;
      end
    end
  end

  // Receiver stall pattern: phases of always-ready, random, and heavy stalls.
  always @(negedge clk_i) begin
    int phase;
    phase = ($realtime / 20 / 300);
    case (phase % 3)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= ($urandom_range(0, 3) != 0);
      default: out_ready_i <= ($urandom_range(0, 4) == 0);
    endcase
  end

  int gap_left = 0;
  int burst_left = 0;

  // Present one item from the falling edge and hold it until the transfer.
  // Valid stays high into the next item unless a gap drops it.
  task automatic send_pixel(input rgbe_pkg::in_t x);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
    end
    if (gap_left > 0) begin
      in_valid_i <= 1'b0;
      while (gap_left > 0) begin
        @(negedge clk_i);
        gap_left--;
      end
    end
    burst_left--;
    in_data_i <= x;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (x.cmd == rgbe_pkg::CMD_PACK) n_pack++;
    else n_unpack++;
    @(negedge clk_i);
  endtask

  function automatic rgbe_pkg::in_t pack_item(input logic [31:0] r, g, b);
    rgbe_pkg::in_t x;
    x = '0;
    x.cmd = rgbe_pkg::CMD_PACK;
    x.red_in = r;
    x.green_in = g;
    x.blue_in = b;
    x.packed_in = $urandom();
    return x;
  endfunction

  function automatic rgbe_pkg::in_t unpack_item(input logic [31:0] w);
    rgbe_pkg::in_t x;
    x = '0;
    x.cmd = rgbe_pkg::CMD_UNPACK;
    x.packed_in = w;
    x.red_in = $urandom();
    x.green_in = $urandom();
    x.blue_in = $urandom();
    return x;
  endfunction

  // Random channel: mostly sensible positive floats near a shared scale.
  function automatic logic [31:0] rand_channel(input logic [7:0] base);
    logic [7:0] e;
    case ($urandom_range(0, 19))
      0: return $urandom();
      1: return {$urandom_range(0, 1) == 1, 8'hFF, 23'($urandom_range(0, 3) == 0 ? 0 :
                 $urandom())};
      2: return {1'b0, 8'h00, 23'($urandom())};
      3: return {1'b1, 31'($urandom())};
      4: return {1'b0, 8'($urandom_range(250, 254)), 23'($urandom())};
      default: begin
        e = 8'(int'(base) - int'($urandom_range(0, 12)));
        return {1'b0, e, 23'($urandom())};
      end
    endcase
  endfunction

  initial begin
    rgbe_pkg::in_t x;
    logic [7:0] base;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: zeros, floor, negatives, specials, exponent limits, then unpack words.
    send_pixel(pack_item(32'h0, 32'h0, 32'h0));
    send_pixel(pack_item(32'h3F800000, 32'h3F000000, 32'h3E800000));
    send_pixel(pack_item(rgbe_pkg::PACK_FLOOR, 32'h0, 32'h0));
    send_pixel(pack_item(rgbe_pkg::PACK_FLOOR - 1, 32'h1, 32'h007FFFFF));
    send_pixel(pack_item(32'h80000000, 32'hBF800000, 32'hFF800000));
    send_pixel(pack_item(rgbe_pkg::INF_BITS, 32'h3F800000, 32'h0));
    send_pixel(pack_item(32'h7FC00000, 32'h0, 32'h0));
    send_pixel(pack_item(32'h0, 32'hFFFFFFFF, 32'h0));
    send_pixel(pack_item(32'h7F000000, 32'h0, 32'h0));
    send_pixel(pack_item(32'h7EFFFFFF, 32'h3F800000, 32'h0));
    send_pixel(pack_item(32'h7F7FFFFF, 32'h0, 32'h0));
    send_pixel(pack_item(32'h47000000, 32'h3F800000, 32'h00000001));
    send_pixel(pack_item(32'h0, 32'h0, 32'h41200000));
    send_pixel(unpack_item(32'h0));
    send_pixel(unpack_item(32'h00FFFFFF));
    send_pixel(unpack_item(32'h01FFFFFF));
    send_pixel(unpack_item(32'h01010101));
    send_pixel(unpack_item(32'h81804020));
    send_pixel(unpack_item(32'hFFFFFFFF));
    send_pixel(unpack_item(32'h0A800001));
    send_pixel(unpack_item(32'hFF000000));

    for (int i = 0; i < NUM_RANDOM; i++) begin
      // Hold off once until everything in flight has drained.
      if (i == NUM_RANDOM / 2) begin
        in_valid_i <= 1'b0;
        @(negedge clk_i);
        while (sb.pending.size() != 0) @(negedge clk_i);
        burst_left = 0;
      end
      if ($urandom_range(0, 1) == 0) begin
        base = 8'($urandom_range(20, 253));
        x = pack_item(rand_channel(base), rand_channel(base), rand_channel(base));
      end else begin
        x = unpack_item($urandom());
      end
      send_pixel(x);
    end
    in_valid_i <= 1'b0;
    stim_done = 1'b1;

    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    $display("covered %0d pack and %0d unpack transfers, %0d overflow results",
             n_pack, n_unpack, n_ovf);
    if (error_count == 0) begin
      $display("[rgbe_shared_exponent_codec] OK");
    end else begin
      $display("%0d mismatches", error_count);
      $display("[rgbe_shared_exponent_codec] ERROR");
    end
    $finish;
  end

endmodule

// ===== rgbe_shared_exponent_codec.f =====
design/rgbe_pkg.sv
design/rgbe_shared_exponent_codec.sv
sim/rgbe_shared_exponent_codec_test.sv
